@@ design/gjps_pkg.sv @@
// Shared types, constants and helpers for the grid jump point scan block.
package gjps_pkg;

	localparam int unsigned CellW   = 16;
	localparam int unsigned WordW   = 32;
	localparam int unsigned WIdxW   = 11;
	localparam int unsigned StrideW = 9;
	localparam int unsigned PosW    = 18;
	localparam int unsigned StepW   = 17;
	localparam int unsigned ColStepW = 12;

	localparam logic [StrideW-1:0] StrideMin   = 9'd32;
	localparam logic [StrideW-1:0] StrideMax   = 9'd256;
	localparam logic [StrideW-1:0] StrideReset = 9'd256;
	localparam logic [CellW-1:0]   CostMax     = 16'hFFFF;

	localparam logic       KindLoad  = 1'b0;
	localparam logic       KindQuery = 1'b1;
	localparam logic [1:0] DirNorth  = 2'd0;
	localparam logic [1:0] DirSouth  = 2'd1;
	localparam logic [1:0] DirEast   = 2'd2;
	localparam logic [1:0] DirWest   = 2'd3;

	typedef struct packed {
		logic               is_load;
		logic               is_col;
		logic               neg;
		logic [WIdxW-1:0]   word_index;
		logic [WordW-1:0]   word_data;
		logic [CellW-1:0]   start_cell;
		logic [CellW-1:0]   goal_cell;
	} cmd_t;

	function automatic logic [CellW-1:0] sat_cost(input logic [PosW-1:0] v);
		if (v[PosW-1]) begin
			return '0;
		end else if (v[PosW-2:CellW] != '0) begin
			return CostMax;
		end else begin
			return v[CellW-1:0];
		end
	endfunction

endpackage

@@ design/grid_jump_point_scan.sv @@
// Top level of the grid jump point scan block.
// Input channel (in_valid/in_ready) carries one word: kind 0 writes a 32-cell
// map word at word_index, kind 1 runs a scan from start_cell in direction
// (0 north, 1 south, 2 east, 3 west) toward goal_cell.
// Output channel (out_valid/out_ready) returns one word per scan: found,
// jump_cell and cost. Map loads return nothing.
// cfg_we/cfg_wdata write row_stride, clamped to 32..256 when used.
// A two-entry command queue separates the front end from the scanner, so
// words are accepted while a scan runs or a result waits.
// With the scanner idle, a map load leaves the queue in the cycle after it is
// accepted. The scanner tests each cell by reading the row above, the row and
// the row below, then evaluating it. A north or south scan reads and checks
// the start column's cell in each row, and per free row runs an east row scan,
// then a west one only if the east scan finds nothing. One scan runs at a time.
// Reset clears queue, scanner and output valid and sets row_stride to 256;
// map contents are undefined until written.
// If the receiver stalls, the result holds and a later finished scan waits
// in the scanner; the queue keeps accepting until full.
module grid_jump_point_scan import gjps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [StrideW-1:0] cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [WIdxW-1:0]   word_index,
	input  logic [WordW-1:0]   word_data,
	input  logic [1:0]         direction,
	input  logic [CellW-1:0]   start_cell,
	input  logic [CellW-1:0]   goal_cell,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [CellW-1:0]   jump_cell,
	output logic [CellW-1:0]   cost
);

	logic q_valid;
	logic q_pop;
	cmd_t q_cmd;

	gjps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.kind       (kind),
		.word_index (word_index),
		.word_data  (word_data),
		.direction  (direction),
		.start_cell (start_cell),
		.goal_cell  (goal_cell),
		.q_valid    (q_valid),
		.q_cmd      (q_cmd),
		.q_pop      (q_pop)
	);

	gjps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.jump_cell (jump_cell),
		.cost      (cost)
	);

endmodule

@@ design/gjps_front.sv @@
// Front end: accepts words, classifies them and queues commands for the scanner.
module gjps_front import gjps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               kind,
	input  logic [WIdxW-1:0]   word_index,
	input  logic [WordW-1:0]   word_data,
	input  logic [1:0]         direction,
	input  logic [CellW-1:0]   start_cell,
	input  logic [CellW-1:0]   goal_cell,
	output logic               q_valid,
	output cmd_t               q_cmd,
	input  logic               q_pop
);

	cmd_t       fifo_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       cmd;
	logic       push;

	always_comb begin
		cmd.is_load    = (kind == KindLoad);
		cmd.is_col     = !direction[1];
		cmd.neg        = (direction == DirNorth) || (direction == DirWest);
		cmd.word_index = word_index;
		cmd.word_data  = word_data;
		cmd.start_cell = start_cell;
		cmd.goal_cell  = goal_cell;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_cmd    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule

@@ design/gjps_back.sv @@
// Back end: map memory, cell-by-cell scan sequencer and result register.
module gjps_back import gjps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [StrideW-1:0] cfg_wdata,
	input  logic               q_valid,
	input  cmd_t               q_cmd,
	output logic               q_pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               found,
	output logic [CellW-1:0]   jump_cell,
	output logic [CellW-1:0]   cost
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_COL_RD, ST_COL_CHK, ST_RD_UP, ST_RD_MID, ST_RD_DN,
		ST_EVAL, ST_ROW_END, ST_DONE
	} state_t;

	state_t                state_q;
	logic [StrideW-1:0]    row_stride_q;
	logic [StrideW-1:0]    stride;
	logic [WordW-1:0]      mem [2048];
	logic [WordW-1:0]      rd_data_q;
	logic [4:0]            rd_bit_q;
	logic                  rd_ok_q;
	logic signed [PosW-1:0] base_q, col_pos_q, cell_c, rd_cell, stride_x, goal_x, gdist;
	logic [StepW-1:0]      idx_q;
	logic [ColStepW-1:0]   col_steps_q;
	logic                  rneg_q, cneg_q, is_col_q;
	logic [CellW-1:0]      goal_q;
	logic                  up_b_q, mid_b_q, prev_up_q, prev_dn_q, dead_q;
	logic                  bit_v, stop, goal_hit, row_found;
	logic [PosW-1:0]       steps_x;
	logic                  res_found_q;
	logic [CellW-1:0]      res_jp_q, res_cost_q;
	logic                  out_valid_q, found_q;
	logic [CellW-1:0]      jump_q, cost_q;

	always_comb begin
		stride = row_stride_q;
		if (row_stride_q < StrideMin) begin
			stride = StrideMin;
		end else if (row_stride_q > StrideMax) begin
			stride = StrideMax;
		end
	end

	assign stride_x = signed'({{(PosW-StrideW){1'b0}}, stride});
	assign goal_x   = signed'({2'b00, goal_q});
	assign cell_c   = rneg_q ? base_q - signed'({1'b0, idx_q}) : base_q + signed'({1'b0, idx_q});

	always_comb begin
		unique case (state_q)
			ST_RD_UP:  rd_cell = cell_c - stride_x;
			ST_RD_DN:  rd_cell = cell_c + stride_x;
			ST_COL_RD: rd_cell = col_pos_q;
			default:   rd_cell = cell_c;
		endcase
	end

	assign q_pop = (state_q == ST_IDLE) && q_valid;

	always_ff @(posedge clk) begin
		if (q_pop && q_cmd.is_load) begin
			mem[q_cmd.word_index] <= q_cmd.word_data;
		end
		rd_data_q <= mem[rd_cell[15:5]];
		rd_bit_q  <= rd_cell[4:0];
		rd_ok_q   <= (rd_cell[PosW-1:CellW] == 2'b00);
	end

	assign bit_v     = rd_ok_q && rd_data_q[rd_bit_q];
	assign stop      = !mid_b_q || ((idx_q != '0) &&
	                   ((up_b_q && !prev_up_q) || (bit_v && !prev_dn_q)));
	assign gdist     = rneg_q ? base_q - goal_x : goal_x - base_q;
	assign steps_x   = {1'b0, idx_q};
	assign goal_hit  = !gdist[PosW-1] && (steps_x > unsigned'(gdist));
	assign row_found = goal_hit || !dead_q;

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				goal_q   <= q_cmd.goal_cell;
				is_col_q <= q_cmd.is_col;
				cneg_q   <= q_cmd.neg;
				rneg_q   <= q_cmd.neg;
				idx_q    <= '0;
				base_q   <= signed'({2'b00, q_cmd.start_cell});
				col_pos_q <= q_cmd.neg ? signed'({2'b00, q_cmd.start_cell}) - stride_x
				                       : signed'({2'b00, q_cmd.start_cell}) + stride_x;
				col_steps_q <= ColStepW'(1);
			end
			ST_COL_CHK: begin
				base_q <= col_pos_q;
				idx_q  <= '0;
				rneg_q <= 1'b0;
				res_found_q <= 1'b0;
				res_jp_q    <= '0;
				res_cost_q  <= CellW'(col_steps_q - ColStepW'(1));
			end
			ST_RD_MID: up_b_q <= bit_v;
			ST_RD_DN:  mid_b_q <= bit_v;
			ST_EVAL: begin
				dead_q    <= !mid_b_q;
				prev_up_q <= up_b_q;
				prev_dn_q <= bit_v;
				if (!stop) begin
					idx_q <= idx_q + StepW'(1);
				end
			end
			ST_ROW_END: begin
				if (is_col_q) begin
					res_found_q <= 1'b1;
					res_jp_q    <= col_pos_q[CellW-1:0];
					res_cost_q  <= CellW'(col_steps_q);
					idx_q       <= '0;
					if (!row_found && rneg_q) begin
						col_pos_q   <= cneg_q ? col_pos_q - stride_x : col_pos_q + stride_x;
						col_steps_q <= col_steps_q + ColStepW'(1);
					end
					rneg_q <= !rneg_q;
				end else if (goal_hit) begin
					res_found_q <= 1'b1;
					res_jp_q    <= goal_q;
					res_cost_q  <= sat_cost(gdist);
				end else if (dead_q) begin
					res_found_q <= 1'b0;
					res_jp_q    <= '0;
					res_cost_q  <= (idx_q == '0) ? '0 : sat_cost(steps_x - PosW'(1));
				end else begin
					res_found_q <= 1'b1;
					res_jp_q    <= cell_c[CellW-1:0];
					res_cost_q  <= sat_cost(steps_x);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			row_stride_q <= StrideReset;
			out_valid_q  <= 1'b0;
			found_q      <= 1'b0;
			jump_q       <= '0;
			cost_q       <= '0;
		end else begin
			if (cfg_we) begin
				row_stride_q <= cfg_wdata;
			end
			if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
				found_q     <= res_found_q;
				jump_q      <= res_jp_q;
				cost_q      <= res_cost_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid && !q_cmd.is_load) begin
						state_q <= q_cmd.is_col ? ST_COL_RD : ST_RD_UP;
					end
				end
				ST_COL_RD:  state_q <= ST_COL_CHK;
				ST_COL_CHK: state_q <= bit_v ? ST_RD_UP : ST_DONE;
				ST_RD_UP:   state_q <= ST_RD_MID;
				ST_RD_MID:  state_q <= ST_RD_DN;
				ST_RD_DN:   state_q <= ST_EVAL;
				ST_EVAL:    state_q <= stop ? ST_ROW_END : ST_RD_UP;
				ST_ROW_END: begin
					if (!is_col_q || row_found) begin
						state_q <= ST_DONE;
					end else if (!rneg_q) begin
						state_q <= ST_RD_UP;
					end else begin
						state_q <= ST_COL_RD;
					end
				end
				ST_DONE: begin
					if (!out_valid_q || out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign jump_cell = jump_q;
	assign cost      = cost_q;

endmodule

@@ design/gjps_checker.sv @@
// Port-level checks for the grid jump point scan block, bound to the top level.
module gjps_checker import gjps_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input logic             out_valid,
	input logic             out_ready,
	input logic             found,
	input logic [CellW-1:0] jump_cell,
	input logic [CellW-1:0] cost
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(jump_cell) && $stable(cost))
		else $error("result dropped or changed while stalled");

	a_dead_jp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> jump_cell == '0)
		else $error("dead end with nonzero jump cell");

	a_full_after_push: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(in_valid))
		else $error("queue filled without an accepted word");

endmodule

bind grid_jump_point_scan gjps_checker u_gjps_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.found     (found),
	.jump_cell (jump_cell),
	.cost      (cost)
);
